[hdl/mpa_pkg.sv]
`default_nettype none

package mpa_pkg;

    // parameter defaults
    localparam int MAX_SIDE_DEF   = 256;
    localparam int MAX_WINDOW_DEF = 4;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int OFF_W    = 10;
    localparam int POOL_W   = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SIDE_REG_W = 9;
    localparam int WIN_REG_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP = 2'd2;

    localparam logic [SIDE_REG_W-1:0] SIDE_RST = 9'd28;
    localparam logic [WIN_REG_W-1:0]  SIZE_RST = 3'd2;
    localparam logic [WIN_REG_W-1:0]  STEP_RST = 3'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       plane_start;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] max_value;
        logic [OFF_W-1:0]           argmax_offset;
        logic [POOL_W-1:0]          pooled_row;
        logic [POOL_W-1:0]          pooled_col;
        logic                       last_of_plane;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cand;
        logic scan_last;
        logic div_done;
        logic rd_busy;
        logic hit;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

[hdl/mpa_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module mpa_div #(
    parameter int DW = 8,
    parameter int SW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic [DW-1:0] o_quot,
    output logic [SW-1:0] o_rem,
    output logic          o_done
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quot;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_div;
    logic [SW:0]      trial;
    logic             ge;

    assign trial = {r_rem, r_quot[DW-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[DW-2:0], ge};
            r_rem  <= ge ? SW'(trial - {1'b0, r_div}) : SW'(trial);
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;
    assign o_done = (r_cnt == '0);

endmodule

`default_nettype wire

[hdl/mpa_ctrl.sv]
`default_nettype none

module mpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output mpa_pkg::t_cmd o_cmd,
    input  mpa_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_sts.cand) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.div_done && !i_sts.rd_busy) begin
                    n_state = i_sts.hit ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[hdl/mpa_dp.sv]
`default_nettype none

module mpa_dp #(
    parameter int MAX_SIDE   = mpa_pkg::MAX_SIDE_DEF,
    parameter int MAX_WINDOW = mpa_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  mpa_pkg::t_in                    i_in_word,
    input  mpa_pkg::t_cmd                   i_cmd,
    output mpa_pkg::t_sts                   o_sts,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output mpa_pkg::t_out                   o_out_word
);

    localparam int POS_W = $clog2(MAX_SIDE);
    localparam int SLW   = $clog2(MAX_WINDOW);
    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = (POS_W + 1 > KW) ? POS_W + 1 : KW;
    localparam int SW_   = mpa_pkg::SAMPLE_W;

    // configuration registers
    logic [mpa_pkg::SIDE_REG_W-1:0] r_cfg_side;
    logic [mpa_pkg::WIN_REG_W-1:0]  r_cfg_size;
    logic [mpa_pkg::WIN_REG_W-1:0]  r_cfg_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_side <= mpa_pkg::SIDE_RST;
            r_cfg_size <= mpa_pkg::SIZE_RST;
            r_cfg_step <= mpa_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mpa_pkg::REG_PLANE_SIDE:  r_cfg_side <= i_cfg_data[mpa_pkg::SIDE_REG_W-1:0];
                mpa_pkg::REG_WINDOW_SIZE: r_cfg_size <= i_cfg_data[mpa_pkg::WIN_REG_W-1:0];
                mpa_pkg::REG_WINDOW_STEP: r_cfg_step <= i_cfg_data[mpa_pkg::WIN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, large values saturate
    logic [CW-1:0] side_eff;
    logic [KW-1:0] k_eff;
    logic [KW-1:0] s_eff;

    always_comb begin
        if (r_cfg_side == '0) begin
            side_eff = CW'(1);
        end else if (32'(r_cfg_side) > 32'(MAX_SIDE)) begin
            side_eff = CW'(MAX_SIDE);
        end else begin
            side_eff = CW'(r_cfg_side);
        end
        if (r_cfg_size == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_cfg_size) > 32'(MAX_WINDOW)) begin
            k_eff = KW'(MAX_WINDOW);
        end else begin
            k_eff = KW'(r_cfg_size);
        end
        if (r_cfg_step == '0) begin
            s_eff = KW'(1);
        end else if (32'(r_cfg_step) > 32'(MAX_WINDOW)) begin
            s_eff = KW'(MAX_WINDOW);
        end else begin
            s_eff = KW'(r_cfg_step);
        end
    end

    // position tracking
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic [SLW-1:0]   r_slot;
    logic [POS_W-1:0] eff_row;
    logic [POS_W-1:0] eff_col;
    logic [SLW-1:0]   eff_slot;
    logic [SLW-1:0]   next_slot;
    logic [CW-1:0]    row_x;
    logic [CW-1:0]    col_x;
    logic [CW-1:0]    row_n1;
    logic [CW-1:0]    col_n1;
    logic [CW-1:0]    kx;
    logic [CW-1:0]    r0_x;
    logic [CW-1:0]    c0_x;
    logic             in_range;
    logic             cand;
    logic             last_now;
    logic [SLW:0]     slot_sum;
    logic [SLW-1:0]   slot0_now;

    assign eff_row  = i_in_word.plane_start ? '0 : r_row;
    assign eff_col  = i_in_word.plane_start ? '0 : r_col;
    assign eff_slot = i_in_word.plane_start ? '0 : r_slot;
    assign row_x    = CW'(eff_row);
    assign col_x    = CW'(eff_col);
    assign row_n1   = row_x + CW'(1);
    assign col_n1   = col_x + CW'(1);
    assign kx       = CW'(k_eff);
    assign r0_x     = row_n1 - kx;
    assign c0_x     = col_n1 - kx;

    assign in_range = (row_x < side_eff) && (col_x < side_eff);
    assign cand     = in_range && (side_eff >= kx) && (row_n1 >= kx) && (col_n1 >= kx);

    // no further window origin fits below or to the right
    assign last_now = ((CW+1)'(row_n1) + (CW+1)'(s_eff) > (CW+1)'(side_eff)) &&
                      ((CW+1)'(col_n1) + (CW+1)'(s_eff) > (CW+1)'(side_eff));

    // row slot holding the window's top row
    always_comb begin
        slot_sum = (SLW+1)'(eff_slot) + (SLW+1)'(MAX_WINDOW) - ((SLW+1)'(k_eff) - (SLW+1)'(1));
        if (slot_sum >= (SLW+1)'(MAX_WINDOW)) begin
            slot_sum = slot_sum - (SLW+1)'(MAX_WINDOW);
        end
        slot0_now = SLW'(slot_sum);
    end

    assign next_slot = (eff_slot == SLW'(MAX_WINDOW - 1)) ? '0 : eff_slot + SLW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_cmd.load) begin
            if (col_n1 >= side_eff) begin
                r_col <= '0;
                if (row_n1 >= side_eff) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= POS_W'(row_n1);
                    r_slot <= next_slot;
                end
            end else begin
                r_row  <= eff_row;
                r_col  <= POS_W'(col_n1);
                r_slot <= eff_slot;
            end
        end
    end

    // window context captured with the item
    logic [POS_W-1:0] r_c0;
    logic [SLW-1:0]   r_slot0;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c0    <= POS_W'(c0_x);
            r_slot0 <= slot0_now;
            r_last  <= last_now;
        end
    end

    // column scan
    logic [SLW-1:0]   r_wc;
    logic             r_rd_vld;
    logic [SLW-1:0]   r_rd_col;
    logic [POS_W-1:0] rd_addr;

    assign rd_addr = r_c0 + POS_W'(r_wc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_wc <= '0;
            end else if (i_cmd.issue) begin
                r_wc <= r_wc + SLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_col <= r_wc;
    end

    // one line memory per row slot, all read at the same column
    logic [SW_-1:0] col_val [MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_row
        logic [SW_-1:0] r_mem [MAX_SIDE];
        logic [SW_-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load && in_range && (eff_slot == SLW'(g))) begin
                r_mem[eff_col] <= i_in_word.sample;
            end
            if (i_cmd.issue) begin
                r_q <= r_mem[rd_addr];
            end
        end

        assign col_val[g] = r_q;
    end

    // best of one column, top row first on ties
    logic signed [SW_-1:0] col_best;
    logic [SLW-1:0]        col_wr;

    always_comb begin
        logic [SLW:0] sl;
        sl       = '0;
        col_best = $signed(col_val[r_slot0]);
        col_wr   = '0;
        for (int wr = 1; wr < MAX_WINDOW; wr++) begin
            sl = (SLW+1)'(r_slot0) + (SLW+1)'(wr);
            if (sl >= (SLW+1)'(MAX_WINDOW)) begin
                sl = sl - (SLW+1)'(MAX_WINDOW);
            end
            if ((KW'(wr) < k_eff) && ($signed(col_val[SLW'(sl)]) > col_best)) begin
                col_best = $signed(col_val[SLW'(sl)]);
                col_wr   = SLW'(wr);
            end
        end
    end

    // running best; a later column wins an equal value only from a higher row
    logic signed [SW_-1:0] r_best;
    logic [SLW-1:0]        r_bwr;
    logic [SLW-1:0]        r_bwc;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if ((r_rd_col == '0) || (col_best > r_best) ||
                ((col_best == r_best) && (col_wr < r_bwr))) begin
                r_best <= col_best;
                r_bwr  <= col_wr;
                r_bwc  <= r_rd_col;
            end
        end
    end

    // origin divided by step: quotient is the pooled index, remainder must be zero
    logic [POS_W-1:0] q_row;
    logic [POS_W-1:0] q_col;
    logic [KW-1:0]    rem_row;
    logic [KW-1:0]    rem_col;
    logic             done_row;
    logic             done_col;

    mpa_div #(
        .DW (POS_W),
        .SW (KW)
    ) u_div_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (POS_W'(r0_x)),
        .i_divisor  (s_eff),
        .o_quot     (q_row),
        .o_rem      (rem_row),
        .o_done     (done_row)
    );

    mpa_div #(
        .DW (POS_W),
        .SW (KW)
    ) u_div_col (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (POS_W'(c0_x)),
        .i_divisor  (s_eff),
        .o_quot     (q_col),
        .o_rem      (rem_col),
        .o_done     (done_col)
    );

    // output register
    logic [SLW+CW-1:0] off_full;
    mpa_pkg::t_out     r_out;
    logic              r_out_vld;

    assign off_full = (SLW+CW)'(r_bwr) * (SLW+CW)'(side_eff) + (SLW+CW)'(r_bwc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.max_value     <= r_best;
            r_out.argmax_offset <= mpa_pkg::OFF_W'(off_full);
            r_out.pooled_row    <= mpa_pkg::POOL_W'(q_row);
            r_out.pooled_col    <= mpa_pkg::POOL_W'(q_col);
            r_out.last_of_plane <= r_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    assign o_sts.cand      = cand;
    assign o_sts.scan_last = (r_wc == SLW'(k_eff - KW'(1)));
    assign o_sts.div_done  = done_row && done_col;
    assign o_sts.rd_busy   = r_rd_vld;
    assign o_sts.hit       = (rem_row == '0) && (rem_col == '0);
    assign o_sts.out_busy  = r_out_vld && i_out_stall;

endmodule

`default_nettype wire

[hdl/max_pool_2d_argmax.sv]
`default_nettype none

// 2-d max pooling with argmax over a square plane streamed in raster order, one
// signed q8.8 pixel per input word. plane_start on a word restarts the position at
// (0,0); otherwise the position wraps after the last pixel of the plane, so planes
// may follow back to back. a pixel that closes a window (side window_size, origins
// every window_step pixels, only windows wholly inside the plane) yields one output
// word: the maximum, its offset window_row*plane_side+window_col (earliest pixel in
// raster order wins ties), the pooled row and column, and a mark on the plane's
// final result. a pixel that could close no window is taken without a stall. a
// pixel that could close a window stalls the input while the window origin is
// divided by the step one bit per cycle and, beside it, the window is read one
// column per cycle from MAX_WINDOW line memories, one per row slot: the stall
// lasts until both are done and, when a word results, for as long as the
// previous word is still stalled in the output register; when the step skips
// the window no word results and the output is not waited for. a finished
// word waits in the output register, so the next pixel is taken while it waits;
// only the next window result waits for it to drain. register values of zero act
// as one, larger values saturate at MAX_SIDE or MAX_WINDOW; write configuration
// only while idle. the line memories need no clearing after reset.
module max_pool_2d_argmax #(
    parameter int MAX_SIDE   = mpa_pkg::MAX_SIDE_DEF,
    parameter int MAX_WINDOW = mpa_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel words in
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mpa_pkg::t_in                    i_in_word,
    // pooled words out
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mpa_pkg::t_out                   o_out_word
);

    mpa_pkg::t_cmd cmd;
    mpa_pkg::t_sts sts;

    // sequencer: take pixel, scan columns, wait for divide, emit
    mpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // registers, position, line memories, compare, dividers, output register
    mpa_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[hdl/mpa_chk.sv]
`default_nettype none

module mpa_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input mpa_pkg::t_in                    i_in_word,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input mpa_pkg::t_out                   o_out_word
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // a stalled pixel word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while stalled");

    // a new result only comes out of a busy phase
    a_rise_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a window in progress");

    // the block is ready for the next pixel as soon as a result is posted
    a_ready_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still stalled after result posted");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind max_pool_2d_argmax mpa_chk u_chk (.*);

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;

    localparam int MAX_SIDE      = mpa_pkg::MAX_SIDE_DEF;
    localparam int MAX_WIN       = mpa_pkg::MAX_WINDOW_DEF;
    // quiet cycles after the last pooled word, well past the window scan latency
    localparam int SETTLE_CYCLES = 32;
    // cycles with no word moving on either side before the run is declared hung
    localparam int HANG_LIMIT    = 4000;
    localparam int RANDOM_WORDS  = 630;

    // clock, reset and block ports
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_idx   = mpa_pkg::REG_PLANE_SIDE;
    logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    mpa_pkg::t_in                   in_word   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mpa_pkg::t_out                  out_word;

    // both sides run without idling while this is set
    logic                           steady      = 1'b0;
    int                             mismatches  = 0;
    int                             hang_cycles = 0;

    // pooling predictor state: line memory, raster position, raw registers
    logic [mpa_pkg::SAMPLE_W-1:0]   line_mem [MAX_WIN*MAX_SIDE];
    int unsigned                    pix_row  = 0;
    int unsigned                    pix_col  = 0;
    logic [mpa_pkg::SIDE_REG_W-1:0] side_reg = mpa_pkg::SIDE_RST;
    logic [mpa_pkg::WIN_REG_W-1:0]  size_reg = mpa_pkg::SIZE_RST;
    logic [mpa_pkg::WIN_REG_W-1:0]  step_reg = mpa_pkg::STEP_RST;

    // pooled words still owed by the block, oldest first
    mpa_pkg::t_out                  pooled_q [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    max_pool_2d_argmax DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // zero acts as one, anything above the maximum saturates
    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // one row slot per line memory, indexed by column
    function automatic int unsigned mem_slot(int unsigned r, int unsigned c);
        return (r % MAX_WIN) * MAX_SIDE + c;
    endfunction

    // extremes and small values often, so ties and sign edges show up
    function automatic logic [mpa_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h7fff;
            end
            2: begin
                return 16'h0000;
            end
            3: begin
                return 16'hffff;
            end
            default: begin
                return mpa_pkg::SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    // store the accepted pixel, and when it closes a window queue the pooled word
    task automatic pool_predict(input mpa_pkg::t_in w);
        int unsigned side, k, s, r, c, r0, c0, pr, pc, pooled, best_off;
        logic signed [mpa_pkg::SAMPLE_W-1:0] best, v;
        mpa_pkg::t_out res;
        side = clamp_reg(side_reg, MAX_SIDE);
        k    = clamp_reg(size_reg, MAX_WIN);
        s    = clamp_reg(step_reg, MAX_WIN);
        if (w.plane_start) begin
            pix_row = 0;
            pix_col = 0;
        end
        r = pix_row;
        c = pix_col;
        // a position left outside a shrunken plane writes nothing
        if (r < side && c < side) begin
            line_mem[mem_slot(r, c)] = w.sample;
            if (side >= k && r + 1 >= k && c + 1 >= k &&
                (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
                r0       = r + 1 - k;
                c0       = c + 1 - k;
                best     = line_mem[mem_slot(r0, c0)];
                best_off = 0;
                // strict compare keeps the earliest pixel on ties
                for (int wr = 0; wr < k; wr++) begin
                    for (int wc = 0; wc < k; wc++) begin
                        v = line_mem[mem_slot(r0 + wr, c0 + wc)];
                        if (v > best) begin
                            best     = v;
                            best_off = wr * side + wc;
                        end
                    end
                end
                pooled = (side - k) / s + 1;
                pr     = r0 / s;
                pc     = c0 / s;
                res.max_value     = best;
                res.argmax_offset = best_off[mpa_pkg::OFF_W-1:0];
                res.pooled_row    = pr[mpa_pkg::POOL_W-1:0];
                res.pooled_col    = pc[mpa_pkg::POOL_W-1:0];
                res.last_of_plane = (pr + 1 == pooled) && (pc + 1 == pooled);
                pooled_q.push_back(res);
            end
        end
        // raster advance, wrapping to the next plane
        if (c + 1 >= side) begin
            pix_col = 0;
            pix_row = (r + 1 >= side) ? 0 : r + 1;
        end else begin
            pix_col = c + 1;
        end
    endtask

    // all three registers on back-to-back cycles, only while the block is idle
    task automatic set_config(input logic [mpa_pkg::CFG_DATA_W-1:0] side_val,
                              input logic [mpa_pkg::CFG_DATA_W-1:0] size_val,
                              input logic [mpa_pkg::CFG_DATA_W-1:0] step_val);
        cfg_we   <= 1'b1;
        cfg_idx  <= mpa_pkg::REG_PLANE_SIDE;
        cfg_data <= side_val;
        @(posedge clk);
        cfg_idx  <= mpa_pkg::REG_WINDOW_SIZE;
        cfg_data <= size_val;
        @(posedge clk);
        cfg_idx  <= mpa_pkg::REG_WINDOW_STEP;
        cfg_data <= step_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        side_reg = side_val;
        size_reg = size_val[mpa_pkg::WIN_REG_W-1:0];
        step_reg = step_val[mpa_pkg::WIN_REG_W-1:0];
    endtask

    // one pixel word: optional idle gap, then hold until the block takes it
    task automatic send_pixel(input logic [mpa_pkg::SAMPLE_W-1:0] px, input logic start);
        if (!steady && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (!steady && $urandom_range(0, 99) < 32);
        end
        in_word.sample      <= px;
        in_word.plane_start <= start;
        in_valid            <= 1'b1;
        do @(posedge clk); while (in_stall);
        pool_predict(in_word);
    endtask

    // stop sending until every pooled word is back, then let the block settle
    task automatic drain_pool();
        in_valid <= 1'b0;
        do @(posedge clk); while (pooled_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // 4x4 plane, 2x2 windows: most negative, most positive, sign edges and ties
    task automatic test_extreme_samples();
        logic [mpa_pkg::SAMPLE_W-1:0] pix [16];
        pix = '{16'h8000, 16'h8000, 16'h0000, 16'hffff,
                16'h8000, 16'h8000, 16'hffff, 16'h0000,
                16'h7fff, 16'h0064, 16'h0005, 16'h0005,
                16'h0064, 16'h7fff, 16'h0005, 16'h0006};
        set_config(9'd4, 9'd2, 9'd2);
        foreach (pix[i]) send_pixel(pix[i], i == 0);
        drain_pool();
    endtask

    // zero registers act as one; oversize window on a small plane gives nothing
    task automatic test_register_limits();
        set_config(9'd0, 9'd0, 9'd0);
        for (int i = 0; i < 3; i++) send_pixel(pick_sample(), i == 0);
        drain_pool();
        set_config(9'd2, 9'd7, 9'd5);
        for (int i = 0; i < 4; i++) send_pixel(pick_sample(), i == 0);
        drain_pool();
    endtask

    // side shrinks while the position sits past the new edge: no word, then wrap
    task automatic test_shrink_mid_plane();
        set_config(9'd6, 9'd2, 9'd2);
        for (int i = 0; i < 23; i++) send_pixel(pick_sample(), i == 0);
        drain_pool();
        set_config(9'd4, 9'd2, 9'd2);
        // one pixel lands outside, then a whole 4x4 plane without plane_start
        for (int i = 0; i < 17; i++) send_pixel(pick_sample(), 1'b0);
        drain_pool();
    endtask

    // saturated side register, one full row of 1x1 windows
    task automatic test_wide_plane();
        set_config(9'h1ff, 9'd1, 9'd1);
        for (int i = 0; i < MAX_SIDE; i++) send_pixel(pick_sample(), i == 0);
        drain_pool();
    endtask

    // random settings, mostly whole planes, with restarts and cut planes mixed in
    task automatic test_random_planes();
        int unsigned sent, side, planes, len;
        logic [mpa_pkg::CFG_DATA_W-1:0] size_val, step_val;
        logic start;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            side     = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20)
                                                   : $urandom_range(0, 10);
            size_val = mpa_pkg::CFG_DATA_W'($urandom_range(0, 7));
            step_val = mpa_pkg::CFG_DATA_W'($urandom_range(0, 7));
            // upper data bits are ignored by the window registers
            if ($urandom_range(0, 3) == 0) begin
                size_val[mpa_pkg::CFG_DATA_W-1:mpa_pkg::WIN_REG_W] =
                    (mpa_pkg::CFG_DATA_W - mpa_pkg::WIN_REG_W)'($urandom);
            end
            if ($urandom_range(0, 3) == 0) begin
                step_val[mpa_pkg::CFG_DATA_W-1:mpa_pkg::WIN_REG_W] =
                    (mpa_pkg::CFG_DATA_W - mpa_pkg::WIN_REG_W)'($urandom);
            end
            set_config(mpa_pkg::CFG_DATA_W'(side), size_val, step_val);
            planes = $urandom_range(1, 3);
            for (int p = 0; p < planes && sent < RANDOM_WORDS; p++) begin
                len = clamp_reg(side, MAX_SIDE) * clamp_reg(side, MAX_SIDE);
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
                for (int i = 0; i < len && sent < RANDOM_WORDS; i++) begin
                    steady = (sent >= 300 && sent < 450);
                    // first plane after a write must restart; later ones may just wrap
                    start  = (i == 0 && (p == 0 || $urandom_range(0, 1) == 1)) ||
                             ($urandom_range(0, 39) == 0);
                    send_pixel(pick_sample(), start);
                    sent++;
                end
            end
            drain_pool();
        end
        steady = 1'b0;
    endtask

    // receiver stalls at random outside the steady stretch
    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < 32);
    end

    // compare each pooled word with the oldest prediction
    always @(posedge clk) begin
        mpa_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pooled_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pooled word %p", out_word);
            end else begin
                want = pooled_q.pop_front();
                if (out_word.max_value     !== want.max_value     ||
                    out_word.argmax_offset !== want.argmax_offset ||
                    out_word.pooled_row    !== want.pooled_row    ||
                    out_word.pooled_col    !== want.pooled_col    ||
                    out_word.last_of_plane !== want.last_of_plane) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected max %0d off %0d at (%0d,%0d) last %0d",
                                 want.max_value, want.argmax_offset, want.pooled_row,
                                 want.pooled_col, want.last_of_plane);
                        $display("          got      max %0d off %0d at (%0d,%0d) last %0d",
                                 out_word.max_value, out_word.argmax_offset,
                                 out_word.pooled_row, out_word.pooled_col,
                                 out_word.last_of_plane);
                    end
                end
            end
        end
    end

    // hang detection: no word moved on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
        if (hang_cycles >= HANG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_extreme_samples();
        test_register_limits();
        test_shrink_mid_plane();
        test_wide_plane();
        test_random_planes();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
